[rtl/rbps_pkg.sv]
// Package: sizes, codes and state encoding for the ready bitmap priority scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rbps_pkg;

  // Sizing of the ready-queue tracker
  localparam int NUM_PRIOS   = 256;
  localparam int GROUP_WIDTH = 16;
  localparam int COUNT_WIDTH = 8;

  localparam int NUM_GROUPS  = (NUM_PRIOS + GROUP_WIDTH - 1) / GROUP_WIDTH;
  localparam int PAD_W       = NUM_GROUPS * GROUP_WIDTH;
  localparam int PRIO_IDX_W  = (NUM_PRIOS > 1) ? $clog2(NUM_PRIOS) : 1;
  localparam int GRP_IDX_W   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int BIT_IDX_W   = $clog2(GROUP_WIDTH);

  // Fixed field widths of the stream items
  localparam int OP_W        = 2;
  localparam int PRIO_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - PRIO_W - 1 - STATUS_W;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_UPDATE = 2'd1,
    S_RESULT = 2'd2
  } fsm_e;

endpackage

`default_nettype wire

[rtl/ready_bitmap_priority_scheduler.sv]
// Top level: ready-queue tracker with a count memory and a two-level ready bitmap.
// Each item goes through the count read on accept, the update state and the result state,
// where it is encoded into the output register; no new item is taken until then.
// The next item is taken while a finished result still waits in the output register.
// Reset (rst_ni low, asynchronous) clears the control state, the per-entry valid bits
// of the count memory and the ready bitmap; counts read as zero at once, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module ready_bitmap_priority_scheduler
  import rbps_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] prio
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,   // [1:0] operation
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // [7:0] highest_prio, [8] any_ready,
                                                      // [10:9] status
);

  // Control and item registers
  fsm_e                   state_q, state_d;
  op_e                    op_q;
  logic [PRIO_W-1:0]      prio_q;
  logic                   vld_at_q;
  status_e                status_q, status_d;

  // Count memory, its valid bits and the per-priority ready bits
  logic [COUNT_WIDTH-1:0] count_mem [NUM_PRIOS];
  logic [COUNT_WIDTH-1:0] rd_q;
  logic [NUM_PRIOS-1:0]   cnt_vld_q;
  logic [NUM_PRIOS-1:0]   lvl_q;
  logic [PAD_W-1:0]       lvl_pad;
  logic [NUM_GROUPS-1:0]  grp_ne;

  // Output register
  logic                   out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic                   in_acc;
  logic                   prio_ok;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] cnt_nxt;
  logic                   wr_en;
  logic                   out_load;
  logic [GRP_IDX_W-1:0]   top_grp;
  logic [GROUP_WIDTH-1:0] top_word;
  logic [BIT_IDX_W-1:0]   top_b;
  logic [PRIO_W-1:0]      hi_prio;
  logic                   any_rdy;

  // Highest set bit of the group vector
  function automatic logic [GRP_IDX_W-1:0] enc_grp(input logic [NUM_GROUPS-1:0] v);
    logic [GRP_IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      if (v[i]) begin
        r = GRP_IDX_W'(i);
      end
    end
    return r;
  endfunction

  // Highest set bit of one priority word
  function automatic logic [BIT_IDX_W-1:0] enc_bit(input logic [GROUP_WIDTH-1:0] v);
    logic [BIT_IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < GROUP_WIDTH; i++) begin
      if (v[i]) begin
        r = BIT_IDX_W'(i);
      end
    end
    return r;
  endfunction

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == S_RESULT) && (!out_vld_q || m_axis_tready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    m_axis_tvalid = out_vld_q;
    m_axis_tdata  = out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the item and the valid bit of its count entry
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= op_e'(s_axis_tuser[OP_W-1:0]);
      prio_q   <= s_axis_tdata[PRIO_W-1:0];
      vld_at_q <= cnt_vld_q[s_axis_tdata[PRIO_IDX_W-1:0]];
    end
  end

  // Read-modify-write of the count for the item's priority
  assign prio_ok = (32'(prio_q) < NUM_PRIOS);
  assign cnt_cur = vld_at_q ? rd_q : '0;

  always_comb begin
    status_d = ST_OK;
    cnt_nxt  = cnt_cur;
    wr_en    = 1'b0;
    unique case (op_q)
      OP_APPEND: begin
        if (!prio_ok || cnt_cur == COUNT_MAX) begin
          status_d = ST_OVERFLOW;
        end else begin
          cnt_nxt = cnt_cur + COUNT_WIDTH'(1);
          wr_en   = (state_q == S_UPDATE);
        end
      end
      OP_REMOVE: begin
        if (!prio_ok || cnt_cur == '0) begin
          status_d = ST_EMPTY;
        end else begin
          cnt_nxt = cnt_cur - COUNT_WIDTH'(1);
          wr_en   = (state_q == S_UPDATE);
        end
      end
      OP_QUERY, OP_RSVD: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_UPDATE) begin
      status_q <= status_d;
    end
  end

  // Count memory: synchronous read on accept, write back in the update cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= count_mem[s_axis_tdata[PRIO_IDX_W-1:0]];
    end
    if (wr_en) begin
      count_mem[prio_q[PRIO_IDX_W-1:0]] <= cnt_nxt;
    end
  end

  // Mark written entries and keep the ready bit in step with the count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      lvl_q     <= '0;
    end else if (wr_en) begin
      cnt_vld_q[prio_q[PRIO_IDX_W-1:0]] <= 1'b1;
      lvl_q[prio_q[PRIO_IDX_W-1:0]]     <= (cnt_nxt != '0);
    end
  end

  // Group bits: a group is set while any priority in its word is ready
  assign lvl_pad = PAD_W'(lvl_q);

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_ne[g] = |lvl_pad[g*GROUP_WIDTH +: GROUP_WIDTH];
    end
  end

  // Two-level search: top group, then top bit in that word
  always_comb begin
    any_rdy  = |grp_ne;
    top_grp  = enc_grp(grp_ne);
    top_word = lvl_pad[top_grp*GROUP_WIDTH +: GROUP_WIDTH];
    top_b    = enc_bit(top_word);
    hi_prio  = any_rdy ? PRIO_W'(32'(top_grp) * GROUP_WIDTH + 32'(top_b)) : '0;
  end

  // Output register: load when empty or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {OUT_PAD_W'(0), status_q, any_rdy, hi_prio};
    end
  end

  // An accepted item always goes to the update cycle next
  a_acc_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_UPDATE))
    else $error("accepted item did not enter the update cycle");

  // Nothing ready means the reported priority is zero
  a_none_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !any_rdy) |-> (hi_prio == '0))
    else $error("highest priority nonzero with nothing ready");

  // A count dropping to zero clears the ready bit
  a_zero_clears_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && cnt_nxt == '0) |=> !lvl_q[$past(prio_q[PRIO_IDX_W-1:0])])
    else $error("ready bit left set for an empty priority");

  // Overflow only comes from an append, empty only from a remove
  a_status_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) |->
      ((status_d != ST_OVERFLOW || op_q == OP_APPEND) &&
       (status_d != ST_EMPTY || op_q == OP_REMOVE)))
    else $error("status does not match the operation");

  // A reported ready priority has its ready bit set
  a_top_is_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && any_rdy) |-> top_word[top_b])
    else $error("reported priority is not ready");

endmodule

`default_nettype wire

[bench/ready_bitmap_priority_scheduler_test.sv]
// Self-checking stream test of the ready bitmap priority scheduler.
`timescale 1ns / 1ps

module ready_bitmap_priority_scheduler_test;
  import rbps_pkg::*;

  localparam int ITEMS       = 1850;
  localparam int CALM_ITEMS  = 200;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 12;

  // One scheduler answer as it appears on the result stream
  typedef struct packed {
    logic [PRIO_W-1:0] top_prio;
    logic              ready;
    status_e           status;
  } sched_answer_t;

  // Ready-queue predictor plus the store of answers still owed by the block
  class sched_scoreboard;
    logic [COUNT_WIDTH-1:0] thread_cnt [NUM_PRIOS];
    logic [GROUP_WIDTH-1:0] prio_word [NUM_GROUPS];
    logic [NUM_GROUPS-1:0]  group_bits;
    sched_answer_t          owed_q [$];
    int                     errors;

    function new();
      foreach (thread_cnt[i]) thread_cnt[i] = '0;
      foreach (prio_word[i]) prio_word[i] = '0;
      group_bits = '0;
      errors     = 0;
    endfunction

    // Walk the group bitmap, then the word of the highest busy group
    function void find_top(output logic [PRIO_W-1:0] top, output logic ready);
      int g;
      int b;
      g     = 0;
      b     = 0;
      top   = '0;
      ready = |group_bits;
      if (ready) begin
        for (int i = 0; i < NUM_GROUPS; i++) if (group_bits[i]) g = i;
        for (int i = 0; i < GROUP_WIDTH; i++) if (prio_word[g][i]) b = i;
        top = PRIO_W'(g * GROUP_WIDTH + b);
      end
    endfunction

    // Apply one accepted item and queue the answer it owes
    function void note_item(op_e op, logic [PRIO_W-1:0] prio);
      sched_answer_t ans;
      int            g;
      int            b;
      g          = int'(prio) / GROUP_WIDTH;
      b          = int'(prio) % GROUP_WIDTH;
      ans.status = ST_OK;
      case (op)
        OP_APPEND: begin
          if (int'(prio) >= NUM_PRIOS || thread_cnt[prio] == COUNT_MAX) begin
            ans.status = ST_OVERFLOW;
          end else begin
            thread_cnt[prio]++;
            prio_word[g][b] = 1'b1;
            group_bits[g]   = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (int'(prio) >= NUM_PRIOS || thread_cnt[prio] == '0) begin
            ans.status = ST_EMPTY;
          end else begin
            thread_cnt[prio]--;
            if (thread_cnt[prio] == '0) begin
              prio_word[g][b] = 1'b0;
              if (prio_word[g] == '0) group_bits[g] = 1'b0;
            end
          end
        end
        default: ;
      endcase
      find_top(ans.top_prio, ans.ready);
      owed_q.push_back(ans);
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Compare one result item field by field with the oldest owed answer
    task check_result(logic [OUT_TDATA_W-1:0] data);
      sched_answer_t ans;
      logic [STATUS_W-1:0] got_status;
      if (owed_q.size() == 0) begin
        report($sformatf("result %h with no item pending", data));
        return;
      end
      ans        = owed_q.pop_front();
      got_status = data[PRIO_W+STATUS_W:PRIO_W+1];
      if (data[PRIO_W-1:0] !== ans.top_prio)
        report($sformatf("highest_prio %0d, want %0d", data[PRIO_W-1:0], ans.top_prio));
      if (data[PRIO_W] !== ans.ready)
        report($sformatf("any_ready %b, want %b", data[PRIO_W], ans.ready));
      if (got_status !== ans.status)
        report($sformatf("status %0d, want %0d", got_status, ans.status));
    endtask

    task check_leftover();
      if (owed_q.size() != 0) report($sformatf("%0d results never came", owed_q.size()));
    endtask

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  sched_scoreboard sb;
  int              sent_cnt = 0;
  int              send_idle_pct = 0;
  int              stall_left = 0;
  int              quiet_cycles = 0;
  logic            calm = 1'b0;

  ready_bitmap_priority_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Offer one item, hold it until taken, then maybe idle for a burst
  task automatic send_item(op_e op, logic [PRIO_W-1:0] prio);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= IN_TUSER_W'(op);
    s_axis_tdata  <= prio;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, prio);
    sent_cnt++;
    if (sent_cnt >= ITEMS - CALM_ITEMS) calm = 1'b1;
    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Take results and throttle the result side in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && rst_ni && $urandom_range(0, 99) < 12) stall_left = $urandom_range(1, 14);
    end
  end

  // Count cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [PRIO_W-1:0] pool [4];
    logic [PRIO_W-1:0] top;
    logic              ready;
    logic [PRIO_W-1:0] prio;
    int                burst;
    int                pick;

    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queries, empty removes, extremes, top tracking down to none
    send_item(OP_QUERY, 8'h00);
    send_item(OP_RSVD, 8'hFF);
    send_item(OP_REMOVE, 8'h00);
    send_item(OP_REMOVE, 8'hFF);
    send_item(OP_APPEND, 8'h00);
    send_item(OP_APPEND, 8'hFF);
    send_item(OP_APPEND, 8'h0F);
    send_item(OP_APPEND, 8'h10);
    send_item(OP_APPEND, 8'hAA);
    send_item(OP_APPEND, 8'h55);
    send_item(OP_QUERY, 8'hAA);
    send_item(OP_RSVD, 8'h00);
    send_item(OP_REMOVE, 8'hFF);
    send_item(OP_REMOVE, 8'hAA);
    send_item(OP_REMOVE, 8'h55);
    send_item(OP_REMOVE, 8'h10);
    send_item(OP_APPEND, 8'h80);
    send_item(OP_APPEND, 8'h7F);
    send_item(OP_REMOVE, 8'h80);
    send_item(OP_REMOVE, 8'h7F);
    send_item(OP_REMOVE, 8'h0F);
    send_item(OP_REMOVE, 8'h00);
    send_item(OP_REMOVE, 8'h00);

    // Fill one priority past its count limit, then drain it below empty
    send_idle_pct = 10;
    prio = PRIO_W'($urandom_range(0, NUM_PRIOS - 1));
    while (sb.thread_cnt[prio] != COUNT_MAX) send_item(OP_APPEND, prio);
    repeat (3) send_item(OP_APPEND, prio);
    send_item(OP_QUERY, prio);
    while (sb.thread_cnt[prio] != '0) send_item(OP_REMOVE, prio);
    send_item(OP_REMOVE, prio);

    // Random episodes: pooled traffic, noise, and draining from the top
    while (sent_cnt < ITEMS) begin
      send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
      burst = $urandom_range(8, 40);
      case ($urandom_range(0, 3))
        0, 1: begin
          foreach (pool[i]) pool[i] = PRIO_W'($urandom_range(0, NUM_PRIOS - 1));
          repeat (burst) begin
            pick = $urandom_range(0, 99);
            prio = pool[$urandom_range(0, 3)];
            if (pick < 58) send_item(OP_APPEND, prio);
            else if (pick < 94) send_item(OP_REMOVE, prio);
            else send_item(op_e'($urandom_range(2, 3)), prio);
          end
        end
        2: begin
          repeat (burst)
            send_item(op_e'($urandom_range(0, 3)), PRIO_W'($urandom_range(0, NUM_PRIOS - 1)));
        end
        default: begin
          repeat (burst) begin
            sb.find_top(top, ready);
            send_item(OP_REMOVE, top);
          end
        end
      endcase
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    sb.check_leftover();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
